[hdl/lfp_pkg.sv]
// Package for the lambda fractal pixel block: types, constants, helpers.
package lfp_pkg;
    localparam int IMAGE_SIDE_DEF    = 1024;
    localparam int FRACTION_BITS_DEF = 24;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [2:0] {
        CFG_PIXEL_SCALE  = 3'd0,
        CFG_OFFSET_RE    = 3'd1,
        CFG_OFFSET_IM    = 3'd2,
        CFG_SEED_RE      = 3'd3,
        CFG_SEED_IM      = 3'd4,
        CFG_ITER_LIMIT   = 3'd5,
        CFG_ESCAPE_LIMIT = 3'd6,
        CFG_COLOR_MULT   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [9:0] pixel_col;
        logic signed [9:0] pixel_row;
    } t_in_req;

    typedef struct packed {
        logic        pixel_written;
        logic [15:0] escape_count;
        logic [23:0] pixel_color;
    } t_out_req;

    typedef struct packed {
        logic        outside;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
    } t_job;

    typedef struct packed {
        logic [30:0] pixel_scale;
        logic signed [31:0] offset_re;
        logic signed [31:0] offset_im;
        logic signed [31:0] seed_re;
        logic signed [31:0] seed_im;
        logic [15:0] iteration_limit;
        logic [30:0] escape_limit;
        logic [23:0] color_mult;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEED, ST_SQ, ST_T, ST_N, ST_ESC, ST_COLOR, ST_DONE
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(66'(a) - 66'(b));
    endfunction
endpackage

[hdl/lambda_fractal_pixel.sv]
// Top level of the lambda fractal pixel block.
// Usage:
//  - i_cfg_*: write a register (index per register list) while idle.
//  - i_valid/o_ready carries a pixel request (centred col,row).
//  - o_valid/i_ready returns one result request per pixel.
// Path, request to result: front register, queue, back-end load, seed test,
//  then per iteration square, combine, multiply by c and escape test, until
//  escape (then colour) or the iteration limit; a seed that has already
//  escaped goes straight to colour. A pixel outside the image skips the
//  seed test and the iterations.
// The back end takes its next pixel the cycle after a result is registered;
//  it works on one pixel at a time, and the iteration loop sets the rate.
// Front end and queue take new pixels while the back end iterates.
// Reset (synchronous, active low) empties queue and result register and
//  loads register defaults.
// A stalled receiver holds the result; the back end waits, the queue
//  fills, then o_ready drops.
module lambda_fractal_pixel import lfp_pkg::*; #(
    parameter int IMAGE_SIDE    = IMAGE_SIDE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_req     i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_req    o_req,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_cfg r_cfg;
    logic f_v, f_r, q_v, q_r;
    t_job f_j, q_j;

    assign o_cfg_ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_scale     <= 31'd32768;
            r_cfg.offset_re       <= '0;
            r_cfg.offset_im       <= '0;
            r_cfg.seed_re         <= '0;
            r_cfg.seed_im         <= '0;
            r_cfg.iteration_limit <= 16'd100;
            r_cfg.escape_limit    <= 31'd67108864;
            r_cfg.color_mult      <= 24'd660520;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PIXEL_SCALE:  r_cfg.pixel_scale     <= i_cfg_data[30:0];
                CFG_OFFSET_RE:    r_cfg.offset_re       <= i_cfg_data;
                CFG_OFFSET_IM:    r_cfg.offset_im       <= i_cfg_data;
                CFG_SEED_RE:      r_cfg.seed_re         <= i_cfg_data;
                CFG_SEED_IM:      r_cfg.seed_im         <= i_cfg_data;
                CFG_ITER_LIMIT:   r_cfg.iteration_limit <= i_cfg_data[15:0];
                CFG_ESCAPE_LIMIT: r_cfg.escape_limit    <= i_cfg_data[30:0];
                CFG_COLOR_MULT:   r_cfg.color_mult      <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    lfp_front #(.IMAGE_SIDE(IMAGE_SIDE)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req, .i_cfg(r_cfg),
        .o_valid(f_v), .i_ready(f_r), .o_job(f_j));

    lfp_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_job(f_j),
        .o_valid(q_v), .i_ready(q_r), .o_job(q_j));

    lfp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_job(q_j),
        .i_cfg(r_cfg), .o_valid, .i_ready, .o_req);
endmodule

[hdl/lfp_front.sv]
// Front end: range check and c = pixel*scale + offset.
module lfp_front import lfp_pkg::*; #(
    parameter int IMAGE_SIDE = IMAGE_SIDE_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in_req i_req,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    input  logic    i_ready,
    output t_job    o_job
);
    localparam int HALF = IMAGE_SIDE / 2;
    logic r_full;
    t_job r_job;
    logic signed [65:0] w_pr, w_pi;
    logic signed [12:0] w_c, w_r;
    logic w_out;

    assign w_c = 13'(i_req.pixel_col);
    assign w_r = 13'(i_req.pixel_row);
    assign w_out = (w_c < -13'(HALF)) || (w_c > 13'(HALF - 1)) ||
                   (w_r < -13'(HALF)) || (w_r > 13'(HALF - 1));
    assign w_pr = 66'(i_req.pixel_col) * 66'($signed({1'b0, i_cfg.pixel_scale}));
    assign w_pi = 66'(i_req.pixel_row) * 66'($signed({1'b0, i_cfg.pixel_scale}));
    assign o_ready = !r_full || i_ready;
    assign o_valid = r_full;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_ready) begin
            r_full <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job.outside <= w_out;
            r_job.cr <= sadd(sat32(w_pr), i_cfg.offset_re);
            r_job.ci <= sadd(sat32(w_pi), i_cfg.offset_im);
        end
    end
endmodule

[hdl/lfp_queue.sv]
// Small FIFO between front and back ends.
module lfp_queue import lfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    t_job r_mem [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QUEUE_DEPTH):0] r_cnt;
    logic w_wr, w_rd;

    assign o_ready = r_cnt != ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job = r_mem[r_rp];
    assign w_wr = i_valid && o_ready;
    assign w_rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (w_wr ? 1'b1 : 1'b0) - (w_rd ? 1'b1 : 1'b0);
        end
        if (w_wr) r_mem[r_wp] <= i_job;
    end
endmodule

[hdl/lfp_back.sv]
// Back end: lambda map iteration sequencer and colouring.
module lfp_back import lfp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_job     i_job,
    input  t_cfg     i_cfg,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_req
);
    t_state r_state, n_state;
    logic signed [31:0] r_cr, r_ci, r_zr, r_zi, r_tr, r_ti, r_sq0, r_sq1, r_p2;
    logic [15:0] r_k;
    logic r_seed;
    t_out_req r_out;
    logic r_ov;
    logic signed [31:0] m_a [4];
    logic signed [31:0] m_b [4];
    logic signed [31:0] m_p [4];
    logic [7:0] w_ch [3];
    logic w_esc;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m_a[i] = '0;
            m_b[i] = '0;
        end
        unique case (r_state)
            ST_SEED, ST_ESC, ST_SQ: begin
                m_a[0] = r_zr; m_b[0] = r_zr;
                m_a[1] = r_zi; m_b[1] = r_zi;
                m_a[2] = sadd(r_zr, r_zr); m_b[2] = r_zi;
            end
            ST_N: begin
                m_a[0] = r_cr; m_b[0] = r_tr;
                m_a[1] = r_ci; m_b[1] = r_ti;
                m_a[2] = r_cr; m_b[2] = r_ti;
                m_a[3] = r_ci; m_b[3] = r_tr;
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++)
            m_p[i] = sat32((66'(m_a[i]) * 66'(m_b[i])) >>> FRACTION_BITS);
    end

    assign w_esc = !(sadd(m_p[0], m_p[1]) < $signed({1'b0, i_cfg.escape_limit}));
    // mod 255 by folding bytes: 256 == 1 (mod 255)
    for (genvar g = 0; g < 3; g++) begin : g_ch
        logic [23:0] w_prod;
        logic [9:0]  w_s1;
        logic [8:0]  w_s2;
        assign w_prod = 24'(r_k) * 24'(i_cfg.color_mult[8*g +: 8]);
        assign w_s1 = 10'(w_prod[23:16]) + 10'(w_prod[15:8]) + 10'(w_prod[7:0]);
        assign w_s2 = 9'(w_s1[9:8]) + 9'(w_s1[7:0]);
        assign w_ch[g] = (w_s2 >= 9'd255) ? 8'(w_s2 - 9'd255) : w_s2[7:0];
    end

    assign o_ready = r_state == ST_IDLE;
    assign o_valid = r_ov;
    assign o_req = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = i_job.outside ? ST_DONE : ST_SEED;
            ST_SEED:  n_state = w_esc ? ST_COLOR
                              : (i_cfg.iteration_limit == '0 ? ST_DONE : ST_SQ);
            ST_SQ:    n_state = ST_T;
            ST_T:     n_state = ST_N;
            ST_N:     n_state = ST_ESC;
            ST_ESC:   n_state = w_esc ? ST_COLOR
                              : (r_k + 16'd1 == i_cfg.iteration_limit ? ST_DONE : ST_SQ);
            ST_COLOR: n_state = r_ov ? ST_COLOR : ST_IDLE;
            ST_DONE:  n_state = r_ov ? ST_DONE : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ov && i_ready) r_ov <= 1'b0;
            if ((r_state == ST_COLOR || r_state == ST_DONE) && !r_ov) r_ov <= 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_cr <= i_job.cr;
                r_ci <= i_job.ci;
                r_zr <= sadd(32'(1 << (FRACTION_BITS - 1)), i_cfg.seed_re);
                r_zi <= sadd(32'(1 << (FRACTION_BITS - 1)), i_cfg.seed_im);
                r_k <= '0;
                r_seed <= 1'b1;
            end
            ST_SQ: begin
                r_sq0 <= m_p[0];
                r_sq1 <= m_p[1];
                r_p2 <= m_p[2];
            end
            ST_T: begin
                r_tr <= sadd(ssub(r_zr, r_sq0), r_sq1);
                r_ti <= ssub(r_zi, r_p2);
            end
            ST_N: begin
                r_zr <= ssub(m_p[0], m_p[1]);
                r_zi <= sadd(m_p[2], m_p[3]);
            end
            ST_ESC: begin
                r_seed <= 1'b0;
                if (!w_esc) r_k <= r_k + 16'd1;
            end
            ST_COLOR: if (!r_ov) begin
                r_out.pixel_written <= 1'b1;
                r_out.escape_count <= r_seed ? 16'd0 : r_k;
                r_out.pixel_color <= r_seed ? 24'd0 : {w_ch[2], w_ch[1], w_ch[0]};
            end
            ST_DONE: if (!r_ov) r_out <= '0;
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_out))) else $error("result lost");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ESC) |-> (r_k < i_cfg.iteration_limit)) else $error("count over");
endmodule
